### src/lppu_pkg.sv
`timescale 1ns / 1ps

package lppu_pkg;

	// Result kinds
	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_DELTA   = 3'd1;
	localparam logic [2:0] KIND_CONTENT = 3'd2;
	localparam logic [2:0] KIND_VACUUM  = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN = 3'd4;
	localparam logic [2:0] KIND_TRUNC   = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_DELTA_CODE  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_CODE  = 2'd1;
	localparam logic [1:0] CFG_VACUUM_CODE = 2'd2;
	localparam logic [1:0] CFG_BIG_ENDIAN  = 2'd3;

	typedef struct packed {
		logic [7:0] delta_code;
		logic [7:0] image_code;
		logic [7:0] vacuum_code;
		logic       big_endian;
	} cfg_t;

	// One result item, less the run_end marker
	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] seq_number;
		logic [63:0] page_number;
		logic [15:0] delta_total;
		logic [15:0] delta_offset;
		logic [15:0] delta_length;
		logic [7:0]  content_byte;
		logic [15:0] page_position;
		logic        start_flag;
	} res_t;

	// Everything one input byte gives: an optional main result and an optional
	// truncation result, which shares seq_number and page_number with it
	typedef struct packed {
		logic main_v;
		logic trunc_v;
		res_t res;
	} rec_t;

	// Fold one byte into a 64-bit field; a zero count starts a new field
	function automatic logic [63:0] gather64(input logic [63:0] acc, input logic [7:0] b,
		input logic [2:0] cnt, input logic be);
		logic [63:0] base;
		logic [63:0] r;
		base = (cnt == 3'd0) ? 64'd0 : acc;
		if (be) begin
			r = {base[55:0], b};
		end else begin
			r = base | ({56'd0, b} << {cnt, 3'b000});
		end
		return r;
	endfunction

	// Same for a 16-bit field
	function automatic logic [15:0] gather16(input logic [15:0] acc, input logic [7:0] b,
		input logic [2:0] cnt, input logic be);
		logic [15:0] base;
		logic [15:0] r;
		base = (cnt == 3'd0) ? 16'd0 : acc;
		if (be) begin
			r = {base[7:0], b};
		end else begin
			r = base | ({8'd0, b} << {cnt[0], 3'b000});
		end
		return r;
	endfunction

endpackage

### src/lppu_in_if.sv
`timescale 1ns / 1ps

interface lppu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       final_byte;

	modport source (output valid, output payload_byte, output final_byte, input ready);
	modport sink (input valid, input payload_byte, input final_byte, output ready);
endinterface

### src/lppu_out_if.sv
`timescale 1ns / 1ps

interface lppu_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [63:0] seq_number;
	logic [63:0] page_number;
	logic [15:0] delta_total;
	logic [15:0] delta_offset;
	logic [15:0] delta_length;
	logic [7:0]  content_byte;
	logic [15:0] page_position;
	logic        start_flag;
	logic        run_end;

	modport source (output valid, output kind, output seq_number, output page_number,
		output delta_total, output delta_offset, output delta_length, output content_byte,
		output page_position, output start_flag, output run_end, input ready);
	modport sink (input valid, input kind, input seq_number, input page_number,
		input delta_total, input delta_offset, input delta_length, input content_byte,
		input page_position, input start_flag, input run_end, output ready);
endinterface

### src/log_payload_byte_parser_unit.sv
`timescale 1ns / 1ps
// Path: an accepted byte passes the input register, then the result queue, to its first result.
// Throughput: one byte per cycle while the result queue has room; a byte giving two results
// (result then truncation) occupies the output for two transfers of the one-transfer-per-cycle queue.
// Reset: arst_n asynchronous, active low; parser idle awaiting a type byte, queue empty,
// type codes 1, 2, 3 and little-endian fields.

module log_payload_byte_parser_unit
	import lppu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lppu_in_if.sink     payload,
	lppu_out_if.source  result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	cfg_t cfg;
	logic push_valid;
	logic push_ready;
	rec_t push_rec;

	lppu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lppu_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.payload    (payload),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_rec   (push_rec)
	);

	lppu_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_rec   (push_rec),
		.push_ready (push_ready),
		.result     (result)
	);

endmodule

### src/lppu_cfg_regs.sv
`timescale 1ns / 1ps

module lppu_cfg_regs
	import lppu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	// Register file, written one register per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delta_code  <= 8'd1;
			cfg_q.image_code  <= 8'd2;
			cfg_q.vacuum_code <= 8'd3;
			cfg_q.big_endian  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELTA_CODE:  cfg_q.delta_code  <= cfg_wdata;
				CFG_IMAGE_CODE:  cfg_q.image_code  <= cfg_wdata;
				CFG_VACUUM_CODE: cfg_q.vacuum_code <= cfg_wdata;
				CFG_BIG_ENDIAN:  cfg_q.big_endian  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/lppu_parser.sv
`timescale 1ns / 1ps

module lppu_parser
	import lppu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	lppu_in_if.sink   payload,
	input  logic      push_ready,
	output logic      push_valid,
	output rec_t      push_rec
);

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_SEQ   = 4'd1;
	localparam logic [3:0] PH_PAGE  = 4'd2;
	localparam logic [3:0] PH_COUNT = 4'd3;
	localparam logic [3:0] PH_OFF   = 4'd4;
	localparam logic [3:0] PH_LEN   = 4'd5;
	localparam logic [3:0] PH_DATA  = 4'd6;
	localparam logic [3:0] PH_IMAGE = 4'd7;
	localparam logic [3:0] PH_FLAG  = 4'd8;
	localparam logic [3:0] PH_DONE  = 4'd9;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// Parse state
	logic [3:0]  phase_q, phase_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [1:0]  kind_q, kind_n;
	logic [63:0] seq_q, seq_n;
	logic [63:0] page_q, page_n;
	logic [15:0] deltas_q, deltas_n;
	logic [15:0] offs_q, offs_n;
	logic [15:0] left_q, left_n;
	logic [15:0] pos_q, pos_n;

	rec_t rec;
	logic advance;

	// The byte in the input register moves on when its results have room
	assign advance       = valid_s1 && (push_ready || !(rec.main_v || rec.trunc_v));
	assign payload.ready = !valid_s1 || advance;
	assign push_valid    = valid_s1 && (rec.main_v || rec.trunc_v);
	assign push_rec      = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload.ready) begin
			valid_s1 <= payload.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (payload.ready && payload.valid) begin
			byte_s1 <= payload.payload_byte;
			fin_s1  <= payload.final_byte;
		end
	end

	// Next state and results for the byte held in the input register
	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		kind_n   = kind_q;
		seq_n    = seq_q;
		page_n   = page_q;
		deltas_n = deltas_q;
		offs_n   = offs_q;
		left_n   = left_q;
		pos_n    = pos_q;
		rec      = '0;

		unique case (phase_q)
			PH_IDLE: begin
				cnt_n    = 3'd0;
				seq_n    = 64'd0;
				page_n   = 64'd0;
				deltas_n = 16'd0;
				offs_n   = 16'd0;
				left_n   = 16'd0;
				pos_n    = 16'd0;
				phase_n  = PH_SEQ;
				if (byte_s1 == cfg.delta_code) begin
					kind_n = 2'd1;
				end else if (byte_s1 == cfg.image_code) begin
					kind_n = 2'd2;
				end else if (byte_s1 == cfg.vacuum_code) begin
					kind_n = 2'd3;
				end else begin
					kind_n       = 2'd0;
					rec.main_v   = 1'b1;
					rec.res.kind = KIND_UNKNOWN;
					phase_n      = PH_DONE;
				end
			end
			PH_SEQ: begin
				seq_n = gather64(seq_q, byte_s1, cnt_q, cfg.big_endian);
				cnt_n = cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					phase_n = (kind_q == 2'd3) ? PH_FLAG : PH_PAGE;
				end
			end
			PH_PAGE: begin
				page_n = gather64(page_q, byte_s1, cnt_q, cfg.big_endian);
				cnt_n  = cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					if (kind_q == 2'd1) begin
						phase_n = PH_COUNT;
					end else begin
						rec.main_v   = 1'b1;
						rec.res.kind = KIND_HEADER;
						pos_n        = 16'd0;
						phase_n      = PH_IMAGE;
					end
				end
			end
			PH_COUNT: begin
				deltas_n = gather16(deltas_q, byte_s1, cnt_q, cfg.big_endian);
				cnt_n    = cnt_q + 3'd1;
				if (cnt_q == 3'd1) begin
					cnt_n               = 3'd0;
					rec.main_v          = 1'b1;
					rec.res.kind        = KIND_HEADER;
					rec.res.delta_total = deltas_n;
					phase_n             = (deltas_n != 16'd0) ? PH_OFF : PH_DONE;
				end
			end
			PH_OFF: begin
				offs_n = gather16(offs_q, byte_s1, cnt_q, cfg.big_endian);
				cnt_n  = cnt_q + 3'd1;
				if (cnt_q == 3'd1) begin
					cnt_n   = 3'd0;
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				left_n = gather16(left_q, byte_s1, cnt_q, cfg.big_endian);
				cnt_n  = cnt_q + 3'd1;
				if (cnt_q == 3'd1) begin
					cnt_n                = 3'd0;
					rec.main_v           = 1'b1;
					rec.res.kind         = KIND_DELTA;
					rec.res.delta_offset = offs_q;
					rec.res.delta_length = left_n;
					pos_n                = offs_q;
					if (left_n == 16'd0) begin
						// empty delta: straight on to the next one
						deltas_n = deltas_q - 16'd1;
						phase_n  = (deltas_n != 16'd0) ? PH_OFF : PH_DONE;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				rec.main_v            = 1'b1;
				rec.res.kind          = KIND_CONTENT;
				rec.res.content_byte  = byte_s1;
				rec.res.page_position = pos_q;
				pos_n                 = pos_q + 16'd1;
				left_n                = left_q - 16'd1;
				if (left_n == 16'd0) begin
					cnt_n    = 3'd0;
					deltas_n = deltas_q - 16'd1;
					phase_n  = (deltas_n != 16'd0) ? PH_OFF : PH_DONE;
				end
			end
			PH_IMAGE: begin
				rec.main_v            = 1'b1;
				rec.res.kind          = KIND_CONTENT;
				rec.res.content_byte  = byte_s1;
				rec.res.page_position = pos_q;
				pos_n                 = pos_q + 16'd1;
			end
			PH_FLAG: begin
				rec.main_v           = 1'b1;
				rec.res.kind         = KIND_VACUUM;
				rec.res.start_flag   = (byte_s1 != 8'd0);
				phase_n              = PH_DONE;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		// Both results show the fields gathered up to and including this byte
		rec.res.seq_number  = seq_n;
		rec.res.page_number = page_n;

		// End of payload: flag an unfinished structure, then back to idle
		if (fin_s1) begin
			rec.trunc_v = (phase_n != PH_DONE) && (phase_n != PH_IMAGE);
			phase_n     = PH_IDLE;
			cnt_n       = 3'd0;
			kind_n      = 2'd0;
			seq_n       = 64'd0;
			page_n      = 64'd0;
			deltas_n    = 16'd0;
			offs_n      = 16'd0;
			left_n      = 16'd0;
			pos_n       = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= 3'd0;
			kind_q   <= 2'd0;
			seq_q    <= 64'd0;
			page_q   <= 64'd0;
			deltas_q <= 16'd0;
			offs_q   <= 16'd0;
			left_q   <= 16'd0;
			pos_q    <= 16'd0;
		end else if (advance) begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			kind_q   <= kind_n;
			seq_q    <= seq_n;
			page_q   <= page_n;
			deltas_q <= deltas_n;
			offs_q   <= offs_n;
			left_q   <= left_n;
			pos_q    <= pos_n;
		end
	end

`ifndef ASSERT_OFF
	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fin_s1) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after final byte");

	a_no_trunc_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_rec.trunc_v) |-> (phase_n == PH_IDLE && fin_s1))
		else $error("truncation result without final byte");

	a_field_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_SEQ && phase_q != PH_PAGE) |-> (cnt_q <= 3'd1))
		else $error("field byte count out of range for phase");
`endif

endmodule

### src/lppu_result_queue.sv
`timescale 1ns / 1ps

module lppu_result_queue
	import lppu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  rec_t      push_rec,
	output logic      push_ready,
	lppu_out_if.source result
);

	// Two-entry queue of records; one record gives one or two transfers
	rec_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       second_q;

	rec_t head;
	logic show_trunc;
	logic push;
	logic pop;

	assign head       = mem_q[rd_ptr_q];
	assign show_trunc = second_q || !head.main_v;
	assign push_ready = (count_q != 2'd2);
	assign push       = push_valid && push_ready;
	assign pop        = result.valid && result.ready && result.run_end;

	// Result presentation
	assign result.valid         = (count_q != 2'd0);
	assign result.kind          = show_trunc ? KIND_TRUNC : head.res.kind;
	assign result.seq_number    = head.res.seq_number;
	assign result.page_number   = head.res.page_number;
	assign result.delta_total   = show_trunc ? 16'd0 : head.res.delta_total;
	assign result.delta_offset  = show_trunc ? 16'd0 : head.res.delta_offset;
	assign result.delta_length  = show_trunc ? 16'd0 : head.res.delta_length;
	assign result.content_byte  = show_trunc ? 8'd0 : head.res.content_byte;
	assign result.page_position = show_trunc ? 16'd0 : head.res.page_position;
	assign result.start_flag    = show_trunc ? 1'b0 : head.res.start_flag;
	assign result.run_end       = show_trunc || !head.trunc_v;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers, fill count and main-result-sent flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			second_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				second_q <= 1'b0;
			end else if (result.valid && result.ready) begin
				second_q <= 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue overfilled");

	a_second_has_both: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (result.valid && head.main_v && head.trunc_v))
		else $error("second transfer pending without a two-result record");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_rec.main_v || push_rec.trunc_v))
		else $error("empty record queued");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench
	import lppu_pkg::*;
();

	// Parser phases of the predictor
	typedef enum logic [3:0] {
		P_TYPE, P_SEQ, P_PAGE, P_COUNT, P_OFFSET, P_LENGTH,
		P_DELTA_DATA, P_IMAGE_DATA, P_FLAG, P_DONE
	} parse_phase_e;

	typedef enum logic [1:0] {PK_NONE, PK_DELTA, PK_IMAGE, PK_VACUUM} payload_kind_e;

	typedef struct packed {
		logic run_end;
		res_t res;
	} parse_result_t;

	// Payload parser predictor plus the queue of results still owed by the block
	class payload_scoreboard;
		logic [7:0]    delta_code = 8'd1;
		logic [7:0]    image_code = 8'd2;
		logic [7:0]    vacuum_code = 8'd3;
		logic          be = 1'b0;
		parse_phase_e  phase = P_TYPE;
		logic [3:0]    field_cnt = '0;
		payload_kind_e pkind = PK_NONE;
		logic [63:0]   seq_acc = '0;
		logic [63:0]   page_acc = '0;
		logic [15:0]   deltas_left = '0;
		logic [15:0]   cur_offset = '0;
		logic [15:0]   bytes_left = '0;
		logic [15:0]   position = '0;
		parse_result_t expected_q[$];
		int            mismatches = 0;
		int            results_checked = 0;

		function void set_reg(logic [1:0] idx, logic [7:0] v);
			case (idx)
				CFG_DELTA_CODE:  delta_code = v;
				CFG_IMAGE_CODE:  image_code = v;
				CFG_VACUUM_CODE: vacuum_code = v;
				CFG_BIG_ENDIAN:  be = v[0];
				default: ;
			endcase
		endfunction

		// Type byte lookup, delta code has priority, then image, then vacuum
		function payload_kind_e classify(logic [7:0] b);
			if (b == delta_code) return PK_DELTA;
			if (b == image_code) return PK_IMAGE;
			if (b == vacuum_code) return PK_VACUUM;
			return PK_NONE;
		endfunction

		function void clear_parse();
			phase = P_TYPE;
			field_cnt = '0;
			pkind = PK_NONE;
			seq_acc = '0;
			page_acc = '0;
			deltas_left = '0;
			cur_offset = '0;
			bytes_left = '0;
			position = '0;
		endfunction

		// Shift one byte into a multi-byte field; first byte restarts the field
		function logic [63:0] fold(logic [63:0] acc, logic [7:0] b);
			if (field_cnt == 0) acc = '0;
			if (be) return {acc[55:0], b};
			return acc | ({56'd0, b} << (8 * field_cnt[2:0]));
		endfunction

		function void push(logic [2:0] kind, logic [15:0] total, logic [15:0] off,
			logic [15:0] len, logic [7:0] cb, logic [15:0] pos, logic flag);
			parse_result_t r;
			r.run_end = 1'b0;
			r.res.kind = kind;
			r.res.seq_number = seq_acc;
			r.res.page_number = page_acc;
			r.res.delta_total = total;
			r.res.delta_offset = off;
			r.res.delta_length = len;
			r.res.content_byte = cb;
			r.res.page_position = pos;
			r.res.start_flag = flag;
			expected_q.push_back(r);
		endfunction

		function void end_delta();
			deltas_left = deltas_left - 16'd1;
			field_cnt = '0;
			phase = (deltas_left != 0) ? P_OFFSET : P_DONE;
		endfunction

		// One accepted payload byte: advance the parser and queue its results
		function void note_byte(logic [7:0] b, logic fin);
			int first;
			first = expected_q.size();
			case (phase)
				P_TYPE: begin
					clear_parse();
					pkind = classify(b);
					if (pkind == PK_NONE) begin
						push(KIND_UNKNOWN, 0, 0, 0, 0, 0, 0);
						phase = P_DONE;
					end else begin
						phase = P_SEQ;
					end
				end
				P_SEQ: begin
					seq_acc = fold(seq_acc, b);
					field_cnt++;
					if (field_cnt == 8) begin
						field_cnt = '0;
						phase = (pkind == PK_VACUUM) ? P_FLAG : P_PAGE;
					end
				end
				P_PAGE: begin
					page_acc = fold(page_acc, b);
					field_cnt++;
					if (field_cnt == 8) begin
						field_cnt = '0;
						if (pkind == PK_DELTA) begin
							phase = P_COUNT;
						end else begin
							push(KIND_HEADER, 0, 0, 0, 0, 0, 0);
							position = '0;
							phase = P_IMAGE_DATA;
						end
					end
				end
				P_COUNT: begin
					deltas_left = 16'(fold({48'd0, deltas_left}, b));
					field_cnt++;
					if (field_cnt == 2) begin
						field_cnt = '0;
						push(KIND_HEADER, deltas_left, 0, 0, 0, 0, 0);
						phase = (deltas_left != 0) ? P_OFFSET : P_DONE;
					end
				end
				P_OFFSET: begin
					cur_offset = 16'(fold({48'd0, cur_offset}, b));
					field_cnt++;
					if (field_cnt == 2) begin
						field_cnt = '0;
						phase = P_LENGTH;
					end
				end
				P_LENGTH: begin
					bytes_left = 16'(fold({48'd0, bytes_left}, b));
					field_cnt++;
					if (field_cnt == 2) begin
						field_cnt = '0;
						push(KIND_DELTA, 0, cur_offset, bytes_left, 0, 0, 0);
						position = cur_offset;
						if (bytes_left == 0) end_delta();
						else phase = P_DELTA_DATA;
					end
				end
				P_DELTA_DATA: begin
					push(KIND_CONTENT, 0, 0, 0, b, position, 0);
					position = position + 16'd1;
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 0) end_delta();
				end
				P_IMAGE_DATA: begin
					push(KIND_CONTENT, 0, 0, 0, b, position, 0);
					position = position + 16'd1;
				end
				P_FLAG: begin
					push(KIND_VACUUM, 0, 0, 0, 0, 0, b != 8'd0);
					phase = P_DONE;
				end
				default: phase = P_DONE;
			endcase
			// early end of payload
			if (fin) begin
				if (phase != P_DONE && phase != P_IMAGE_DATA)
					push(KIND_TRUNC, 0, 0, 0, 0, 0, 0);
				clear_parse();
			end
			if (expected_q.size() > first)
				expected_q[expected_q.size() - 1].run_end = 1'b1;
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(parse_result_t got);
			parse_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected, kind %0d", got.res.kind);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			cmp_field("kind", 64'(want.res.kind), 64'(got.res.kind));
			cmp_field("seq_number", want.res.seq_number, got.res.seq_number);
			cmp_field("page_number", want.res.page_number, got.res.page_number);
			cmp_field("delta_total", 64'(want.res.delta_total), 64'(got.res.delta_total));
			cmp_field("delta_offset", 64'(want.res.delta_offset), 64'(got.res.delta_offset));
			cmp_field("delta_length", 64'(want.res.delta_length), 64'(got.res.delta_length));
			cmp_field("content_byte", 64'(want.res.content_byte), 64'(got.res.content_byte));
			cmp_field("page_position", 64'(want.res.page_position),
				64'(got.res.page_position));
			cmp_field("start_flag", 64'(want.res.start_flag), 64'(got.res.start_flag));
			cmp_field("run_end", 64'(want.run_end), 64'(got.run_end));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_wdata;

	lppu_in_if  byte_ch();
	lppu_out_if res_ch();

	payload_scoreboard sb = new();

	logic [7:0] pl_q[$];
	int         bytes_sent = 0;
	int         settings_used = 1;
	bit         idle_on = 1'b1;
	bit         hold_req = 1'b0;

	log_payload_byte_parser_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.payload   (byte_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	initial begin
		#1000000;
		$display("** log_payload_byte_parser_unit: FAILED **");
		$finish;
	end

	// Monitors: byte transfers, register writes, result transfers
	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready)
			sb.note_byte(byte_ch.payload_byte, byte_ch.final_byte);
		if (arst_n && cfg_we)
			sb.set_reg(cfg_index, cfg_wdata);
	end

	always @(posedge clk) begin
		parse_result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.run_end = res_ch.run_end;
			got.res.kind = res_ch.kind;
			got.res.seq_number = res_ch.seq_number;
			got.res.page_number = res_ch.page_number;
			got.res.delta_total = res_ch.delta_total;
			got.res.delta_offset = res_ch.delta_offset;
			got.res.delta_length = res_ch.delta_length;
			got.res.content_byte = res_ch.content_byte;
			got.res.page_position = res_ch.page_position;
			got.res.start_flag = res_ch.start_flag;
			sb.check_result(got);
		end
	end

	// Result side ready: random stall bursts, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready = 1'b0;
				repeat (79) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall > 0) begin
				res_ch.ready = 1'b0;
				stall--;
			end else begin
				res_ch.ready = 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					stall = $urandom_range(1, 11);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		byte_ch.valid = 1'b1;
		byte_ch.payload_byte = b;
		byte_ch.final_byte = fin;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	task automatic input_gap(input int n);
		repeat (n) begin
			@(negedge clk);
			byte_ch.valid = 1'b0;
		end
	endtask

	// Hold the input until every owed result is in, then let the pipe settle
	task automatic wait_drained();
		@(negedge clk);
		byte_ch.valid = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = v;
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] dc, input logic [7:0] ic,
		input logic [7:0] vc, input logic big);
		write_reg(CFG_DELTA_CODE, dc);
		write_reg(CFG_IMAGE_CODE, ic);
		write_reg(CFG_VACUUM_CODE, vc);
		write_reg(CFG_BIG_ENDIAN, {7'd0, big});
		@(negedge clk);
		cfg_we = 1'b0;
		settings_used++;
	endtask

	// Payload assembly
	task automatic begin_payload(input logic [7:0] t);
		pl_q.delete();
		pl_q.push_back(t);
	endtask

	task automatic add_rand(input int n);
		repeat (n) pl_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_fill(input int n, input logic [7:0] v);
		repeat (n) pl_q.push_back(v);
	endtask

	task automatic add16(input logic [15:0] v);
		if (sb.be) begin
			pl_q.push_back(v[15:8]);
			pl_q.push_back(v[7:0]);
		end else begin
			pl_q.push_back(v[7:0]);
			pl_q.push_back(v[15:8]);
		end
	endtask

	task automatic add_delta_entry(input logic [15:0] off, input logic [15:0] len,
		input int data_n);
		add16(off);
		add16(len);
		add_rand(data_n);
	endtask

	task automatic send_payload();
		for (int i = 0; i < pl_q.size(); i++) begin
			if (idle_on && $urandom_range(0, 5) == 0)
				input_gap($urandom_range(1, 11));
			send_byte(pl_q[i], i == pl_q.size() - 1);
		end
	endtask

	// Mostly well-formed payloads; some cut short, some with trailing bytes
	task automatic build_random();
		int            pick;
		int            cnt;
		int            len;
		int            keep;
		logic [7:0]    t;
		logic [15:0]   off;
		payload_kind_e k;
		pick = $urandom_range(0, 99);
		if (pick < 40) t = sb.delta_code;
		else if (pick < 65) t = sb.image_code;
		else if (pick < 82) t = sb.vacuum_code;
		else begin
			do t = 8'($urandom_range(0, 255)); while (sb.classify(t) != PK_NONE);
		end
		k = sb.classify(t);
		begin_payload(t);
		case (k)
			PK_DELTA: begin
				add_rand(16);
				cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 3);
				add16(16'(cnt));
				repeat ((cnt > 3) ? 2 : cnt) begin
					off = ($urandom_range(0, 3) == 0) ? 16'hFFF8 + 16'($urandom_range(0, 7))
						: 16'($urandom_range(0, 65535));
					len = $urandom_range(0, 6);
					add_delta_entry(off, 16'(len), len);
				end
			end
			PK_IMAGE:  add_rand(16 + $urandom_range(0, 12));
			PK_VACUUM: begin
				add_rand(8);
				pl_q.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255)));
			end
			default:   add_rand($urandom_range(0, 3));
		endcase
		if ($urandom_range(0, 4) == 0 && pl_q.size() > 1) begin
			keep = $urandom_range(1, pl_q.size() - 1);
			while (pl_q.size() > keep) void'(pl_q.pop_back());
		end else if (k != PK_IMAGE && $urandom_range(0, 6) == 0) begin
			add_rand($urandom_range(1, 3));
		end
	endtask

	task automatic run_random(input int budget);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			build_random();
			send_payload();
		end
	endtask

	// Directed payloads under the reset codes
	task automatic run_directed();
		// unknown type with ignored tail
		begin_payload(8'h00); add_fill(2, 8'hA5); send_payload();
		// vacuum, flag clear and flag set with trailing bytes
		begin_payload(sb.vacuum_code); add_fill(8, 8'hFF); pl_q.push_back(8'h00);
		send_payload();
		begin_payload(sb.vacuum_code); add_rand(8); pl_q.push_back(8'h80); add_rand(2);
		send_payload();
		// delta with zero count
		begin_payload(sb.delta_code); add_fill(8, 8'hFF); add_fill(8, 8'h00); add16(16'd0);
		send_payload();
		// position wrap, then a zero-length delta
		begin_payload(sb.delta_code); add_rand(16); add16(16'd2);
		add_delta_entry(16'hFFFE, 16'd3, 3); add_delta_entry(16'd0, 16'd0, 0);
		send_payload();
		// image ending with its page id, then one with data
		begin_payload(sb.image_code); add_fill(8, 8'h00); add_fill(8, 8'hFF); send_payload();
		begin_payload(sb.image_code); add_rand(21); send_payload();
		// early ends: on the type byte, inside a long delta, mid sequence, mid page
		begin_payload(sb.delta_code); send_payload();
		begin_payload(sb.delta_code); add_rand(16); add16(16'hFFFF);
		add_delta_entry(16'hFFFF, 16'hFFFF, 2); send_payload();
		begin_payload(sb.vacuum_code); add_rand(4); send_payload();
		begin_payload(sb.image_code); add_rand(11); send_payload();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DELTA_CODE;
		cfg_wdata = 8'd0;
		byte_ch.valid = 1'b0;
		byte_ch.payload_byte = 8'd0;
		byte_ch.final_byte = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset codes, little endian
		idle_on = 1'b1;
		run_directed();
		run_random(90);
		wait_drained();

		// extreme codes, big endian, with a pause for a full drain midway
		configure(8'h00, 8'hFF, 8'h80, 1'b1);
		run_random(45);
		wait_drained();
		run_random(45);
		wait_drained();

		// vacuum code shadowed by delta; no idling, long result hold-off
		configure(8'hFF, 8'h00, 8'hFF, 1'b0);
		idle_on = 1'b0;
		hold_req = 1'b1;
		run_random(90);
		wait_drained();

		// image code shadowed by delta, big endian, hold-off again
		configure(8'h5A, 8'h5A, 8'hA5, 1'b1);
		idle_on = 1'b1;
		hold_req = 1'b1;
		run_random(90);
		wait_drained();

		// random codes, no idling to the end
		configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		idle_on = 1'b0;
		run_random(90);
		wait_drained();
		repeat (10) @(posedge clk);

		if (sb.expected_q.size() != 0)
			$error("%0d expected results never arrived", sb.expected_q.size());
		$display("Run covered %0d payload bytes over %0d register settings, %0d results checked",
			bytes_sent, settings_used, sb.results_checked);
		$display("with truncated, unknown and padded payloads under stalls and hold-off");
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("** log_payload_byte_parser_unit: PASSED **");
		end else begin
			$display("** log_payload_byte_parser_unit: FAILED **");
		end
		$finish;
	end

endmodule
